[hdl/drfl_pkg.sv]
// drfl_pkg: shared types and constants for the dated rate floor lookup core.
// No dependencies.
`default_nettype none
package drfl_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_DATE  = 3'd1;
  localparam logic [2:0] ST_NEGATIVE  = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_LOADED    = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  localparam logic       FUNC_LOAD  = 1'b0;
  localparam logic       FUNC_QUERY = 1'b1;

  localparam logic [15:0] MAX_VALUE_RESET = 16'd1000;

  typedef struct packed {
    logic              func;
    logic [7:0]        year_char_3;
    logic [7:0]        year_char_2;
    logic [7:0]        year_char_1;
    logic [7:0]        year_char_0;
    logic [7:0]        month_char_1;
    logic [7:0]        month_char_0;
    logic [7:0]        day_char_1;
    logic [7:0]        day_char_0;
    logic signed [47:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [63:0] product;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SRCH, S_SRCH_WAIT, S_POS_RD, S_POS_WAIT, S_DECIDE,
    S_SHIFT_RD, S_SHIFT_WAIT, S_SHIFT_WR, S_MUL1, S_MUL2, S_OUT
  } state_t;

  // Days in month, month 1..12; February leap handled separately.
  function automatic logic [4:0] month_days(input logic [3:0] m);
    case (m)
      4'd2: month_days = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_days = 5'd30;
      default: month_days = 5'd31;
    endcase
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage
`default_nettype wire

[hdl/drfl_date_check.sv]
// drfl_date_check: digit, month and day validation of a packed date.
// Uses drfl_pkg.
`default_nettype none
module drfl_date_check (
  input  wire logic [63:0] key,
  output logic             date_ok
);
  logic [7:0] c [8];
  logic       digits_ok;
  logic [3:0] d [8];
  logic [6:0] yy_lo;
  logic [6:0] yy_hi;
  logic [3:0] month;
  logic [6:0] day;
  logic [4:0] dim;
  logic       leap;
  logic [6:0] month_raw;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      c[i] = key[63 - 8*i -: 8];
      d[i] = c[i][3:0];
    end
    digits_ok = 1'b1;
    for (int i = 0; i < 8; i++) digits_ok = digits_ok & drfl_pkg::is_digit(c[i]);
    yy_hi = 7'(d[0]) * 7'd10 + 7'(d[1]);
    yy_lo = 7'(d[2]) * 7'd10 + 7'(d[3]);
    month_raw = 7'(d[4]) * 7'd10 + 7'(d[5]);
    month = month_raw[3:0];
    day = 7'(d[6]) * 7'd10 + 7'(d[7]);
    // divisible by 4 via tens/ones digits; century years use the upper digits
    if (yy_lo == 7'd0) leap = (yy_hi[1:0] == 2'd0);
    else               leap = (yy_lo[1:0] == 2'd0);
    dim = drfl_pkg::month_days(month);
    if (month == 4'd2 && leap) dim = 5'd29;
    date_ok = digits_ok && month_raw >= 7'd1 && month_raw <= 7'd12 &&
              day >= 7'd1 && day <= 7'(dim);
  end
endmodule
`default_nettype wire

[hdl/drfl_table_mem.sv]
// drfl_table_mem: key and rate storage, one write and one read port, registered read.
// No dependencies.
`default_nettype none
module drfl_table_mem #(
  parameter int AW = 10
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [111:0]      wr_data,
  input  wire logic [AW-1:0]     rd_addr,
  output logic [111:0]           rd_data
);
  logic [111:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

[hdl/dated_rate_floor_lookup_core.sv]
// dated_rate_floor_lookup_core: top level, sequencer and multiplier.
// Uses drfl_pkg, drfl_date_check, drfl_table_mem.
`default_nettype none
// One item at a time. A query runs a binary search through the table memory,
// each probe a read and a wait state. A load runs the search too, then for an
// insert moves each entry above the insert point up by one, in a read, wait
// and write step per entry. Results sit in an output register; the next item
// is taken once the result is out.
module dated_rate_floor_lookup_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire drfl_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output drfl_pkg::out_item_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  drfl_pkg::state_t state_r, state_nxt;
  drfl_pkg::in_item_t item_r;
  logic [15:0]  max_value_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [2:0]   status_r, status_nxt;
  logic signed [63:0] product_r, product_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [47:0]  mag_r, mag_nxt;
  logic         neg_r, neg_nxt;
  logic [63:0]  phi_r, phi_nxt, plo_r, plo_nxt;

  logic [63:0]  key;
  logic         date_ok;
  logic         wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [111:0] wr_data, rd_data;
  logic [CW-1:0] mid;
  logic [63:0]  rd_key;
  logic signed [47:0] rd_rate;
  logic [63:0]  res;

  assign key = {item_r.year_char_3, item_r.year_char_2, item_r.year_char_1,
                item_r.year_char_0, item_r.month_char_1, item_r.month_char_0,
                item_r.day_char_1, item_r.day_char_0};
  assign rd_key  = rd_data[111:48];
  assign rd_rate = rd_data[47:0];
  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  drfl_date_check u_date (.key(key), .date_ok(date_ok));

  drfl_table_mem #(.AW(AW)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign in_ready  = (state_r == drfl_pkg::S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = '{status: status_r, product: product_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= drfl_pkg::S_IDLE;
      count_r     <= '0;
      max_value_r <= drfl_pkg::MAX_VALUE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) max_value_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
    lo_r <= lo_nxt; hi_r <= hi_nxt; idx_r <= idx_nxt;
    status_r <= status_nxt; product_r <= product_nxt;
    mag_r <= mag_nxt; neg_r <= neg_nxt; phi_r <= phi_nxt; plo_r <= plo_nxt;
  end

  always_comb begin
    state_nxt = state_r; count_nxt = count_r;
    lo_nxt = lo_r; hi_nxt = hi_r; idx_nxt = idx_r;
    status_nxt = status_r; product_nxt = product_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mag_nxt = mag_r; neg_nxt = neg_r; phi_nxt = phi_r; plo_nxt = plo_r;
    wr_en = 1'b0; wr_addr = idx_r[AW-1:0];
    wr_data = {key, item_r.amount};
    rd_addr = mid[AW-1:0];
    res = '0;
    case (state_r)
      drfl_pkg::S_IDLE: begin
        if (in_valid && in_ready) state_nxt = drfl_pkg::S_CHECK;
      end
      drfl_pkg::S_CHECK: begin
        lo_nxt = '0; hi_nxt = count_r;
        product_nxt = '0; status_nxt = drfl_pkg::ST_OK;
        state_nxt = drfl_pkg::S_SRCH;
        if (item_r.func == drfl_pkg::FUNC_QUERY) begin
          if (!date_ok) begin
            status_nxt = drfl_pkg::ST_BAD_DATE; state_nxt = drfl_pkg::S_OUT;
          end else if (item_r.amount < 0) begin
            status_nxt = drfl_pkg::ST_NEGATIVE; state_nxt = drfl_pkg::S_OUT;
          end else if (48'(item_r.amount) > {16'd0, max_value_r, 16'd0}) begin
            status_nxt = drfl_pkg::ST_TOO_LARGE; state_nxt = drfl_pkg::S_OUT;
          end
        end
      end
      drfl_pkg::S_SRCH: begin
        if (lo_r < hi_r) state_nxt = drfl_pkg::S_SRCH_WAIT;
        else state_nxt = drfl_pkg::S_POS_RD;
      end
      drfl_pkg::S_SRCH_WAIT: begin
        if (rd_key <= key) lo_nxt = mid + 1'b1;
        else hi_nxt = mid;
        state_nxt = drfl_pkg::S_SRCH;
      end
      drfl_pkg::S_POS_RD: begin
        // lo = number of keys <= key; read entry lo-1
        rd_addr = AW'(lo_r - 1'b1);
        state_nxt = drfl_pkg::S_POS_WAIT;
      end
      drfl_pkg::S_POS_WAIT: begin
        // hold the address so the read data stays on entry lo-1
        rd_addr = AW'(lo_r - 1'b1);
        state_nxt = drfl_pkg::S_DECIDE;
      end
      drfl_pkg::S_DECIDE: begin
        rd_addr = AW'(lo_r - 1'b1);
        if (item_r.func == drfl_pkg::FUNC_QUERY) begin
          if (lo_r == '0) begin
            status_nxt = drfl_pkg::ST_NOT_FOUND; state_nxt = drfl_pkg::S_OUT;
          end else begin
            neg_nxt = rd_rate < 0;
            mag_nxt = rd_rate < 0 ? 48'(-rd_rate) : 48'(rd_rate);
            state_nxt = drfl_pkg::S_MUL1;
          end
        end else begin
          status_nxt = drfl_pkg::ST_LOADED;
          if (lo_r != '0 && rd_key == key) begin
            wr_en = 1'b1; wr_addr = AW'(lo_r - 1'b1);
            state_nxt = drfl_pkg::S_OUT;
          end else if (count_r >= CW'(TABLE_DEPTH)) begin
            status_nxt = drfl_pkg::ST_FULL; state_nxt = drfl_pkg::S_OUT;
          end else begin
            idx_nxt = count_r;
            state_nxt = drfl_pkg::S_SHIFT_RD;
          end
        end
      end
      drfl_pkg::S_SHIFT_RD: begin
        if (idx_r == lo_r) begin
          wr_en = 1'b1;
          count_nxt = count_r + 1'b1;
          state_nxt = drfl_pkg::S_OUT;
        end else begin
          rd_addr = AW'(idx_r - 1'b1);
          state_nxt = drfl_pkg::S_SHIFT_WAIT;
        end
      end
      drfl_pkg::S_SHIFT_WAIT: begin
        rd_addr = AW'(idx_r - 1'b1);
        state_nxt = drfl_pkg::S_SHIFT_WR;
      end
      drfl_pkg::S_SHIFT_WR: begin
        wr_en = 1'b1; wr_data = rd_data;
        idx_nxt = idx_r - 1'b1;
        state_nxt = drfl_pkg::S_SHIFT_RD;
      end
      drfl_pkg::S_MUL1: begin
        // value < 2^32, rate split into high 16 and low 32 bits
        phi_nxt = {16'd0, 48'(item_r.amount[31:0]) * 48'(mag_r[47:32])};
        plo_nxt = (64'(item_r.amount[31:0]) * 64'(mag_r[31:0])) >> 16;
        state_nxt = drfl_pkg::S_MUL2;
      end
      drfl_pkg::S_MUL2: begin
        if (phi_r >= 64'h8000_0000_0000) res = 64'h8000_0000_0000_0000;
        else res = (phi_r << 16) + plo_r;
        if (neg_r) begin
          if (res > 64'h8000_0000_0000_0000) res = 64'h8000_0000_0000_0000;
          product_nxt = -res;
        end else begin
          product_nxt = res > 64'h7FFF_FFFF_FFFF_FFFF ? 64'h7FFF_FFFF_FFFF_FFFF : res;
        end
        state_nxt = drfl_pkg::S_OUT;
      end
      drfl_pkg::S_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt = drfl_pkg::S_IDLE;
      end
      default: state_nxt = drfl_pkg::S_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH)) else $error("entry count overflow");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |-> count_r == $past(count_r) + 1'b1)
    else $error("entry count jumped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != drfl_pkg::S_IDLE |-> !in_ready) else $error("accept while busy");
  a_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status_r != drfl_pkg::ST_OK |-> product_r == '0)
    else $error("nonzero product on error");
endmodule
`default_nettype wire
